// ===== rtl/modular_exponentiation_defines.svh =====
// ----------------------------------------------------------------------------
// modular exponentiation assertion macros
// concurrent assertion helpers used by modular_exponentiation.sv, the rtl file that checks itself
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// consequent holds in the cycle of the antecedent
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// constants and controller/datapath interface types for modular exponentiation
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int VAL_W     = 30;
  localparam int IN_EXP_W  = 32;
  localparam int EXP_WIDTH = 32;
  localparam int BIT_CNT_W = $clog2(EXP_WIDTH);

  localparam logic [VAL_W-1:0] PRIME_MOD = 30'd998244353;

  // barrett reduction for products below 2^60
  localparam int PROD_W = 2 * VAL_W;
  localparam int MU_W   = VAL_W + 1;
  localparam logic [63:0] MU_FULL = (64'd1 << PROD_W) / {34'd0, PRIME_MOD};
  localparam logic [MU_W-1:0] BARRETT_MU = MU_FULL[MU_W-1:0];

  localparam logic [31:0] MOD_X1 = {2'b00, PRIME_MOD};
  localparam logic [31:0] MOD_X2 = {1'b0, PRIME_MOD, 1'b0};

  typedef struct packed {
    logic load;
    logic issue_sq;
    logic issue_mul;
    logic shift;
  } mexp_cmd_t;

  typedef struct packed {
    logic mm_done;
    logic exp_msb;
  } mexp_status_t;

endpackage

// ===== rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// base to the exponent modulo 998244353 by msb-first square-and-multiply
// ----------------------------------------------------------------------------
// channel  ports                   transfer
// input    start, base, exponent   start high and busy low at a rising edge
// output   done, power             done high for one cycle, always taken
//
// each exponent bit costs one square, plus one multiply when the bit is set;
// every modular multiply passes through the 4-stage barrett multiplier
// busy drops with done and a new start is taken then
// synchronous reset returns the sequencer to idle and clears the multiplier valid pipe
// the result side has no stall, power is valid only while done is high
// ----------------------------------------------------------------------------
`include "modular_exponentiation_defines.svh"

module modular_exponentiation (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mexp_pkg::VAL_W-1:0]    base,
  input  logic [mexp_pkg::IN_EXP_W-1:0] exponent,
  output logic                         busy,
  output logic                         done,
  output logic [mexp_pkg::VAL_W-1:0]    power
);

  mexp_pkg::mexp_cmd_t    cmd;
  mexp_pkg::mexp_status_t status;

  mexp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mexp_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .base     (base),
    .exponent (exponent),
    .status   (status),
    .power    (power)
  );

  `ASSERT_NEXT(a_accept_sets_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPL(a_done_not_busy, clk, rst, done, !busy)
  `ASSERT_IMPL(a_power_reduced, clk, rst, done, power < mexp_pkg::PRIME_MOD)
  `ASSERT_IMPL(a_mul_only_when_busy, clk, rst, status.mm_done, busy)

endmodule

// ===== rtl/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mexp_mulmod
// four-stage pipelined multiply modulo the prime, barrett reduction
// ----------------------------------------------------------------------------
module mexp_mulmod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [mexp_pkg::VAL_W-1:0] a,
  input  logic [mexp_pkg::VAL_W-1:0] b,
  output logic                      out_valid,
  output logic [mexp_pkg::VAL_W-1:0] res
);

  logic [3:0] vld;

  logic [mexp_pkg::PROD_W-1:0] prod;
  logic [mexp_pkg::PROD_W-1:0] p1;
  logic [61:0]                 t_full;
  logic [61:0]                 t2;
  logic [31:0]                 lo2;
  logic [mexp_pkg::MU_W-1:0]   q;
  logic [60:0]                 qp_full;
  logic [31:0]                 qp3;
  logic [31:0]                 lo3;
  logic [31:0]                 r;
  logic [31:0]                 r_fix;

  assign prod    = a * b;
  assign t_full  = p1[mexp_pkg::PROD_W-1:mexp_pkg::VAL_W-1] * mexp_pkg::BARRETT_MU;
  assign q       = t2[61:31];
  assign qp_full = q * mexp_pkg::PRIME_MOD;

  // true remainder is below three moduli, so 32 bits hold it exactly
  assign r = lo3 - qp3;

  always_comb begin
    if (r >= mexp_pkg::MOD_X2) begin
      r_fix = r - mexp_pkg::MOD_X2;
    end else if (r >= mexp_pkg::MOD_X1) begin
      r_fix = r - mexp_pkg::MOD_X1;
    end else begin
      r_fix = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    p1  <= prod;
    t2  <= t_full;
    lo2 <= p1[31:0];
    qp3 <= qp_full[31:0];
    lo3 <= lo2;
    res <= r_fix[mexp_pkg::VAL_W-1:0];
  end

  assign out_valid = vld[3];

endmodule

// ===== rtl/mexp_datapath.sv =====
// ----------------------------------------------------------------------------
// mexp_datapath
// base, exponent shifter and running accumulator around the modular multiplier
// ----------------------------------------------------------------------------
module mexp_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  mexp_pkg::mexp_cmd_t          cmd,
  input  logic [mexp_pkg::VAL_W-1:0]    base,
  input  logic [mexp_pkg::IN_EXP_W-1:0] exponent,
  output mexp_pkg::mexp_status_t       status,
  output logic [mexp_pkg::VAL_W-1:0]    power
);

  logic [mexp_pkg::VAL_W-1:0]     base_r;
  logic [mexp_pkg::VAL_W-1:0]     base_red;
  logic [mexp_pkg::EXP_WIDTH-1:0] exp_sr;
  logic [mexp_pkg::VAL_W-1:0]     acc;

  logic                       mm_in_valid;
  logic [mexp_pkg::VAL_W-1:0] mm_b;
  logic                       mm_valid;
  logic [mexp_pkg::VAL_W-1:0] mm_res;

  // base stays below twice the modulus, one subtract reduces it
  assign base_red = (base >= mexp_pkg::PRIME_MOD) ? base - mexp_pkg::PRIME_MOD : base;

  assign mm_in_valid = cmd.issue_sq | cmd.issue_mul;
  assign mm_b        = cmd.issue_mul ? base_r : acc;

  mexp_mulmod u_mulmod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mm_in_valid),
    .a         (acc),
    .b         (mm_b),
    .out_valid (mm_valid),
    .res       (mm_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= base_red;
      exp_sr <= mexp_pkg::EXP_WIDTH'(exponent);
      acc    <= {{(mexp_pkg::VAL_W-1){1'b0}}, 1'b1};
    end else begin
      if (cmd.shift) begin
        exp_sr <= {exp_sr[mexp_pkg::EXP_WIDTH-2:0], 1'b0};
      end
      if (mm_valid) begin
        acc <= mm_res;
      end
    end
  end

  assign status.mm_done = mm_valid;
  assign status.exp_msb = exp_sr[mexp_pkg::EXP_WIDTH-1];
  assign power          = acc;

endmodule

// ===== rtl/mexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mexp_ctrl
// sequencer for the msb-first square-and-multiply walk over the exponent
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  mexp_pkg::mexp_status_t status,
  output mexp_pkg::mexp_cmd_t    cmd,
  output logic                   busy,
  output logic                   done
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQ_WAIT,
    ST_MUL,
    ST_MUL_WAIT
  } state_t;

  state_t                        state;
  logic [mexp_pkg::BIT_CNT_W-1:0] cnt;
  logic                          last_bit;
  logic                          advance;

  assign last_bit = (cnt == '0);

  always_comb begin
    cmd     = '0;
    advance = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_SQ: begin
        cmd.issue_sq = 1'b1;
      end
      ST_SQ_WAIT: begin
        advance = status.mm_done & ~status.exp_msb;
      end
      ST_MUL: begin
        cmd.issue_mul = 1'b1;
      end
      ST_MUL_WAIT: begin
        advance = status.mm_done;
      end
      default: begin
        advance = 1'b0;
      end
    endcase
    cmd.shift = advance & ~last_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            busy  <= 1'b1;
            cnt   <= mexp_pkg::BIT_CNT_W'(mexp_pkg::EXP_WIDTH - 1);
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          state <= ST_SQ_WAIT;
        end
        ST_MUL: begin
          state <= ST_MUL_WAIT;
        end
        ST_SQ_WAIT, ST_MUL_WAIT: begin
          if (advance) begin
            if (last_bit) begin
              busy  <= 1'b0;
              done  <= 1'b1;
              state <= ST_IDLE;
            end else begin
              cnt   <= cnt - 1'b1;
              state <= ST_SQ;
            end
          end else if (status.mm_done) begin
            // square done and the bit is set: multiply by the base
            state <= ST_MUL;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks modular_exponentiation against a behavioral square-and-multiply
// model: a directed table of corner cases, then three random phases with
// different amounts of sender idling, every done strobe compared in order
// ----------------------------------------------------------------------------
module tb_top;

  localparam int N_DIRECTED     = 23;
  localparam int ITEMS_PER_RUN  = 576;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_GAP        = 340;
  localparam logic [mexp_pkg::VAL_W-1:0] MOD_M1 = mexp_pkg::PRIME_MOD - 30'd1;
  localparam logic [mexp_pkg::VAL_W-1:0] VAL_ONES = '1;

  typedef struct packed {
    logic [mexp_pkg::VAL_W-1:0]    b;
    logic [mexp_pkg::IN_EXP_W-1:0] e;
    bit                            known;
    logic [mexp_pkg::VAL_W-1:0]    p;
  } power_case_t;

  typedef struct packed {
    logic [mexp_pkg::VAL_W-1:0]    b;
    logic [mexp_pkg::IN_EXP_W-1:0] e;
    logic [mexp_pkg::VAL_W-1:0]    p;
  } power_txn_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [mexp_pkg::VAL_W-1:0] base = '0;
  logic [mexp_pkg::IN_EXP_W-1:0] exponent = '0;
  logic busy;
  logic done;
  logic [mexp_pkg::VAL_W-1:0] power;

  power_txn_t pending_powers[$];
  power_txn_t oldest_power;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned idle_pct = 19;

  // known values where the answer is obvious, predictor for the rest
  power_case_t directed_cases [N_DIRECTED] = '{
    '{30'd0,         32'd0,           1'b1, 30'd1},
    '{MOD_M1,        32'd0,           1'b1, 30'd1},
    '{VAL_ONES,      32'd0,           1'b1, 30'd1},
    '{30'd0,         32'd1,           1'b1, 30'd0},
    '{30'd0,         32'hFFFF_FFFF,   1'b1, 30'd0},
    '{30'd1,         32'hFFFF_FFFF,   1'b1, 30'd1},
    '{30'd12345,     32'd1,           1'b1, 30'd12345},
    '{MOD_M1,        32'd1,           1'b1, MOD_M1},
    '{mexp_pkg::PRIME_MOD, 32'd5,     1'b1, 30'd0},
    '{30'd998244354, 32'd7,           1'b1, 30'd1},
    '{VAL_ONES,      32'd1,           1'b1, 30'd75497470},
    '{MOD_M1,        32'd2,           1'b1, 30'd1},
    '{MOD_M1,        32'd3,           1'b1, MOD_M1},
    '{30'd2,         32'd10,          1'b1, 30'd1024},
    '{30'd2,         32'd29,          1'b1, 30'd536870912},
    '{30'd3,         32'd998244352,   1'b1, 30'd1},
    '{MOD_M1,        32'hFFFF_FFFF,   1'b1, MOD_M1},
    '{MOD_M1,        32'h8000_0000,   1'b1, 30'd1},
    '{VAL_ONES,      32'hFFFF_FFFF,   1'b0, 30'd0},
    '{30'd3,         32'd998244351,   1'b0, 30'd0},
    '{30'd123456789, 32'h8000_0000,   1'b0, 30'd0},
    '{30'h2AAA_AAAA, 32'h5555_5555,   1'b0, 30'd0},
    '{30'h1555_5555, 32'hAAAA_AAAA,   1'b0, 30'd0}
  };

  modular_exponentiation u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .base     (base),
    .exponent (exponent),
    .busy     (busy),
    .done     (done),
    .power    (power)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // msb-first square-and-multiply with the base reduced first
  function automatic logic [mexp_pkg::VAL_W-1:0] mod_power(
    input logic [mexp_pkg::VAL_W-1:0] b,
    input logic [mexp_pkg::IN_EXP_W-1:0] e);
    logic [63:0] m;
    logic [63:0] rb;
    logic [63:0] acc;
    m   = {34'd0, mexp_pkg::PRIME_MOD};
    rb  = {34'd0, b} % m;
    acc = 64'd1;
    for (int i = mexp_pkg::EXP_WIDTH - 1; i >= 0; i--) begin
      acc = (acc * acc) % m;
      if (e[i]) acc = (acc * rb) % m;
    end
    return acc[mexp_pkg::VAL_W-1:0];
  endfunction

  function automatic logic [mexp_pkg::VAL_W-1:0] random_base();
    case ($urandom_range(9))
      0: return mexp_pkg::VAL_W'($urandom_range(0, 3));
      1: return mexp_pkg::VAL_W'($urandom_range(mexp_pkg::PRIME_MOD, 32'h3FFF_FFFF));
      2: return MOD_M1;
      default: return mexp_pkg::VAL_W'($urandom_range(0, MOD_M1));
    endcase
  endfunction

  function automatic logic [mexp_pkg::IN_EXP_W-1:0] random_exponent();
    case ($urandom_range(9))
      0: return '0;
      1: return mexp_pkg::IN_EXP_W'($urandom_range(1, 64));
      2: return '1;
      3: return {2'b00, mexp_pkg::PRIME_MOD} - 32'd2;
      4: return 32'd1 << $urandom_range(31);
      5: return ~(32'd1 << $urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string what, input power_txn_t txn);
    $display("mismatch at %0t: %s base=%0d exponent=%0d got power=%0d expected %0d",
             $time, what, txn.b, txn.e, power, txn.p);
    mismatch_count++;
  endtask

  // at idle_pct odds holds start low for a random gap, then presents the transaction until busy falls
  task automatic send_power_request(input logic [mexp_pkg::VAL_W-1:0] b,
                                    input logic [mexp_pkg::IN_EXP_W-1:0] e,
                                    input logic [mexp_pkg::VAL_W-1:0] want);
    int unsigned gap;
    power_txn_t txn;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    base     <= b;
    exponent <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
    txn.b = b;
    txn.e = e;
    txn.p = want;
    pending_powers.insert(pending_powers.size(), txn);
  endtask

  // result check and watchdog
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (done) begin
        if (pending_powers.size() == 0) begin
          oldest_power = '0;
          report_mismatch("unexpected done", oldest_power);
        end else begin
          oldest_power = pending_powers.pop_front();
          if (power !== oldest_power.p) report_mismatch("wrong power", oldest_power);
        end
      end
      if (done || (start && !busy)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [mexp_pkg::VAL_W-1:0] b;
    logic [mexp_pkg::IN_EXP_W-1:0] e;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_cases[i]) begin
      b = directed_cases[i].b;
      e = directed_cases[i].e;
      send_power_request(b, e, directed_cases[i].known ? directed_cases[i].p
                                                       : mod_power(b, e));
    end

    // sender idling: light, heavy, none
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 19 : (phase == 1) ? 70 : 0;
      repeat (ITEMS_PER_RUN) begin
        b = random_base();
        e = random_exponent();
        send_power_request(b, e, mod_power(b, e));
      end
    end
    start <= 1'b0;

    while (pending_powers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== modular_exponentiation.f =====
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/mexp_datapath.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation.sv
tb/tb_top.sv
